// ===== rtl/pixel_neighbor_curvature_edges_defines.svh =====
// Assertion macros for the pixel neighbor curvature edge builder.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef PIXEL_NEIGHBOR_CURVATURE_EDGES_DEFINES_SVH
`define PIXEL_NEIGHBOR_CURVATURE_EDGES_DEFINES_SVH

// same-cycle implication
`define PNCE_ASSERT_IMPL(label, a, b) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("pnce assertion failed");

// next-cycle implication
`define PNCE_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("pnce assertion failed");

`endif

// ===== rtl/pnce_pkg.sv =====
// Types and constants for the pixel neighbor curvature edge builder.
// No dependencies.
package pnce_pkg;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_RD_UP  = 7'b0000010,
        ST_RD_UR  = 7'b0000100,
        ST_WRITE  = 7'b0001000,
        ST_PICK   = 7'b0010000,
        ST_MAC    = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    // FINISH is folded into PICK when no edge remains
    typedef struct packed {
        logic               has;
        logic               ok;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } pixel_t;

    localparam int PIX_BITS = $bits(pixel_t);

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic [10:0] COLUMNS_RESET = 11'd640;
    localparam logic [10:0] ROWS_RESET    = 11'd480;
    localparam logic [10:0] MAX_ROWS      = 11'd1024;

    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

    localparam logic [1:0] EDGE_RIGHT     = 2'd0;
    localparam logic [1:0] EDGE_DOWNRIGHT = 2'd1;
    localparam logic [1:0] EDGE_DOWN      = 2'd2;
    localparam logic [1:0] EDGE_UPRIGHT   = 2'd3;

endpackage

// ===== rtl/pixel_neighbor_curvature_edges.sv =====
// Pixel neighbor curvature edge builder: raster pixels in, graph edges out.
// Depends on pnce_pkg, pnce_ram and pixel_neighbor_curvature_edges_defines.svh.
// One pixel at a time: s_tready stays low until all edges the pixel causes are emitted, longer
// under output stalls; for each of its 0..4 edges the single shared 33x33 multiplier runs 8 steps.
// Before the first edge leaves, the pixel passes RD_UP, RD_UR, WRITE, PICK, MAC and EMIT.
// Reset (aresetn low, synchronous): counters, ids and left-pixel flags cleared,
// registers back to 640 x 480; line store contents are not cleared.
`include "pixel_neighbor_curvature_edges_defines.svh"

module pixel_neighbor_curvature_edges #(
    parameter int MAX_COLUMNS = 1024,
    parameter int ID_BITS     = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [10:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, nrm_x, nrm_y, nrm_z
    input  logic [95:0]  s_tdata,
    // has_point, normal_ok
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // edge_from, edge_to, edge_weight
    output logic [55:0]  m_tdata,
    output logic         m_tlast
);
    localparam int ADDR_BITS = $clog2(MAX_COLUMNS);
    localparam int COL_BITS  = $clog2(MAX_COLUMNS + 1);
    localparam int RAM_W     = pnce_pkg::PIX_BITS + ID_BITS;

    pnce_pkg::state_t state_reg;

    logic [10:0]         cols_cfg_reg, rows_cfg_reg;
    logic [COL_BITS-1:0] col_reg, x_reg, cols_eff;
    logic [9:0]          row_reg, y_reg;
    logic [10:0]         rows_eff;
    logic [ID_BITS-1:0]  next_id_reg;

    pnce_pkg::pixel_t    cur_reg, up_reg, ur_reg, left0_reg, left1_reg;
    logic [ID_BITS-1:0]  cur_id_reg, up_id_reg, ur_id_reg, left0_id_reg, left1_id_reg;

    logic [3:0]          mask_reg;
    logic [1:0]          edge_reg;
    logic [2:0]          step_reg;
    logic signed [63:0]  prod_reg;
    logic signed [33:0]  dot_reg, c_reg;
    logic signed [35:0]  side_reg;

    logic                out_valid_reg, out_last_reg;
    logic [55:0]         out_data_reg;

    // line store
    logic                ram_we;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [RAM_W-1:0]    ram_q;
    pnce_pkg::pixel_t    ram_pix;
    pnce_pkg::pixel_t    up_fix;

    pnce_ram #(.WIDTH(RAM_W), .DEPTH(MAX_COLUMNS)) u_line (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata({cur_id_reg, cur_reg}),
        .rdata(ram_q)
    );

    assign ram_pix  = pnce_pkg::pixel_t'(ram_q[pnce_pkg::PIX_BITS-1:0]);
    assign ram_we   = (state_reg == pnce_pkg::ST_WRITE);
    logic [COL_BITS-1:0] x_plus1;
    assign x_plus1  = x_reg + COL_BITS'(1);
    assign ram_addr = (state_reg == pnce_pkg::ST_RD_UR) ? x_plus1[ADDR_BITS-1:0]
                                                        : x_reg[ADDR_BITS-1:0];

    always_comb begin
        if (cols_cfg_reg == 11'd0) begin
            cols_eff = COL_BITS'(1);
        end else if (32'(cols_cfg_reg) > MAX_COLUMNS) begin
            cols_eff = COL_BITS'(MAX_COLUMNS);
        end else begin
            cols_eff = COL_BITS'(cols_cfg_reg);
        end
        if (rows_cfg_reg == 11'd0) begin
            rows_eff = 11'd1;
        end else if (rows_cfg_reg > pnce_pkg::MAX_ROWS) begin
            rows_eff = pnce_pkg::MAX_ROWS;
        end else begin
            rows_eff = rows_cfg_reg;
        end
    end

    // edge operands: a is start, b is end
    pnce_pkg::pixel_t   ea, eb;
    logic [ID_BITS-1:0] ea_id, eb_id;
    always_comb begin
        case (edge_reg)
            pnce_pkg::EDGE_RIGHT: begin
                ea = left0_reg; ea_id = left0_id_reg; eb = cur_reg; eb_id = cur_id_reg;
            end
            pnce_pkg::EDGE_DOWNRIGHT: begin
                ea = left1_reg; ea_id = left1_id_reg; eb = cur_reg; eb_id = cur_id_reg;
            end
            pnce_pkg::EDGE_DOWN: begin
                ea = up_reg; ea_id = up_id_reg; eb = cur_reg; eb_id = cur_id_reg;
            end
            default: begin
                ea = cur_reg; ea_id = cur_id_reg; eb = ur_reg; eb_id = ur_id_reg;
            end
        endcase
    end

    // shared multiplier operand select; |c| fits 32 bits unsigned
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [31:0]        c_mag;
    assign c_mag = c_reg[33] ? 32'(-c_reg) : 32'(c_reg);
    always_comb begin
        case (step_reg)
            3'd0: begin mul_a = 33'(ea.nx); mul_b = 33'(eb.nx); end
            3'd1: begin mul_a = 33'(ea.ny); mul_b = 33'(eb.ny); end
            3'd2: begin mul_a = 33'(ea.nz); mul_b = 33'(eb.nz); end
            3'd3: begin mul_a = 33'(eb.nx); mul_b = 33'(eb.px) - 33'(ea.px); end
            3'd4: begin mul_a = 33'(eb.ny); mul_b = 33'(eb.py) - 33'(ea.py); end
            3'd5: begin mul_a = 33'(eb.nz); mul_b = 33'(eb.pz) - 33'(ea.pz); end
            default: begin mul_a = {1'b0, c_mag}; mul_b = {1'b0, c_mag}; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // weight from the finished accumulators
    logic [63:0] sq_round;
    logic [35:0] lin_round;
    logic [15:0] weight;
    assign sq_round  = 64'(prod_reg) + (64'd1 << 41);
    assign lin_round = 36'(c_reg) + 36'd8192;
    always_comb begin
        if (side_reg > 36'sd0) begin
            weight = (sq_round[63:42] > 22'd65535) ? 16'hFFFF : sq_round[57:42];
        end else if (c_reg <= 34'sd0) begin
            weight = 16'd0;
        end else begin
            weight = (lin_round[35:14] > 22'd65535) ? 16'hFFFF : lin_round[29:14];
        end
    end

    logic [3:0] low_bit, mask_rest;
    logic [1:0] low_idx;
    always_comb begin
        low_bit = mask_reg & (~mask_reg + 4'd1);
        low_idx = low_bit[0] ? pnce_pkg::EDGE_RIGHT :
                  low_bit[1] ? pnce_pkg::EDGE_DOWNRIGHT :
                  low_bit[2] ? pnce_pkg::EDGE_DOWN : pnce_pkg::EDGE_UPRIGHT;
        mask_rest = mask_reg & ~(4'b0001 << edge_reg);
    end

    logic cur_good, row_gt0, x_gt0, ur_in;
    assign cur_good = cur_reg.has & cur_reg.ok;
    assign row_gt0  = (y_reg != 10'd0);
    assign x_gt0    = (x_reg != '0);
    assign ur_in    = (x_plus1 < cols_eff);

    // no row above on the first row
    always_comb begin
        up_fix = ram_pix;
        if (!row_gt0) begin
            up_fix.has = 1'b0;
            up_fix.ok  = 1'b0;
        end
    end

    logic [COL_BITS-1:0] col_next;
    logic [10:0]         row_next;
    assign col_next = x_plus1;
    assign row_next = {1'b0, y_reg} + 11'd1;

    logic emit_go;
    assign emit_go = (state_reg == pnce_pkg::ST_EMIT) && (!out_valid_reg || m_tready) &&
                     !cfg_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pnce_pkg::ST_IDLE;
            cols_cfg_reg  <= pnce_pkg::COLUMNS_RESET;
            rows_cfg_reg  <= pnce_pkg::ROWS_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            next_id_reg   <= '0;
            left0_reg.has <= 1'b0;
            left0_reg.ok  <= 1'b0;
            left1_reg.has <= 1'b0;
            left1_reg.ok  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end else begin
            if (emit_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                if (cfg_index == pnce_pkg::CFG_COLUMNS) begin
                    cols_cfg_reg <= cfg_wdata;
                end else begin
                    rows_cfg_reg <= cfg_wdata;
                end
                col_reg       <= '0;
                row_reg       <= '0;
                next_id_reg   <= '0;
                left0_reg.has <= 1'b0;
                left0_reg.ok  <= 1'b0;
                left1_reg.has <= 1'b0;
                left1_reg.ok  <= 1'b0;
            end else begin
                case (state_reg)
                    pnce_pkg::ST_IDLE: begin
                        if (s_tvalid) begin
                            cur_reg.has <= s_tuser[0];
                            cur_reg.ok  <= s_tuser[1];
                            cur_reg.px  <= s_tdata[15:0];
                            cur_reg.py  <= s_tdata[31:16];
                            cur_reg.pz  <= s_tdata[47:32];
                            cur_reg.nx  <= s_tdata[63:48];
                            cur_reg.ny  <= s_tdata[79:64];
                            cur_reg.nz  <= s_tdata[95:80];
                            cur_id_reg  <= next_id_reg;
                            x_reg       <= (col_reg >= cols_eff) ? '0 : col_reg;
                            y_reg       <= ({1'b0, row_reg} >= rows_eff) ? 10'd0 : row_reg;
                            state_reg   <= pnce_pkg::ST_RD_UP;
                        end
                    end
                    pnce_pkg::ST_RD_UP: begin
                        state_reg <= pnce_pkg::ST_RD_UR;
                    end
                    pnce_pkg::ST_RD_UR: begin
                        up_reg     <= up_fix;
                        up_id_reg  <= ram_q[RAM_W-1:pnce_pkg::PIX_BITS];
                        state_reg  <= pnce_pkg::ST_WRITE;
                    end
                    pnce_pkg::ST_WRITE: begin
                        ur_reg    <= ram_pix;
                        ur_id_reg <= ram_q[RAM_W-1:pnce_pkg::PIX_BITS];
                        mask_reg  <= {cur_good & row_gt0 & ur_in & ram_pix.has & ram_pix.ok,
                                      cur_good & up_reg.has & up_reg.ok,
                                      cur_good & row_gt0 & x_gt0 & left1_reg.has &
                                          left1_reg.ok,
                                      cur_good & x_gt0 & left0_reg.has & left0_reg.ok};
                        state_reg <= pnce_pkg::ST_PICK;
                    end
                    pnce_pkg::ST_PICK: begin
                        if (mask_reg != 4'd0) begin
                            edge_reg  <= low_idx;
                            step_reg  <= 3'd0;
                            state_reg <= pnce_pkg::ST_MAC;
                        end else begin
                            // pixel done: shift the left window and advance counters
                            left0_reg    <= cur_reg;
                            left0_id_reg <= cur_id_reg;
                            left1_reg    <= up_reg;
                            left1_id_reg <= up_id_reg;
                            if (col_next >= cols_eff && row_next >= rows_eff) begin
                                next_id_reg <= '0;
                            end else if (cur_reg.has) begin
                                next_id_reg <= next_id_reg + ID_BITS'(1);
                            end
                            if (col_next >= cols_eff) begin
                                col_reg <= '0;
                                if (row_next >= rows_eff) begin
                                    row_reg <= 10'd0;
                                end else begin
                                    row_reg <= row_next[9:0];
                                end
                            end else begin
                                col_reg <= col_next;
                                row_reg <= y_reg;
                            end
                            state_reg <= pnce_pkg::ST_IDLE;
                        end
                    end
                    pnce_pkg::ST_MAC: begin
                        if (step_reg != 3'd6) begin
                            prod_reg <= mul_p[63:0];
                        end
                        case (step_reg)
                            3'd0: begin dot_reg <= '0; side_reg <= '0; end
                            3'd1, 3'd2, 3'd3: dot_reg <= dot_reg + 34'(prod_reg);
                            3'd4, 3'd5, 3'd6: side_reg <= side_reg + 36'(prod_reg);
                            default: ;
                        endcase
                        if (step_reg == 3'd4) begin
                            c_reg <= pnce_pkg::ONE_Q28 - dot_reg;
                        end
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == 3'd7) begin
                            state_reg <= pnce_pkg::ST_EMIT;
                        end
                    end
                    pnce_pkg::ST_EMIT: begin
                        if (emit_go) begin
                            out_data_reg  <= {weight, 20'(eb_id), 20'(ea_id)};
                            out_last_reg  <= (mask_rest == 4'd0);
                            mask_reg      <= mask_rest;
                            state_reg     <= pnce_pkg::ST_PICK;
                        end
                    end
                    default: state_reg <= pnce_pkg::ST_IDLE;
                endcase
            end
        end
    end

    assign s_tready = (state_reg == pnce_pkg::ST_IDLE) && !cfg_we;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `PNCE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `PNCE_ASSERT_IMPL(a_mac_has_edge, state_reg == pnce_pkg::ST_MAC, mask_reg != 4'd0)
    `PNCE_ASSERT_NEXT(a_last_clears_mask, emit_go && mask_rest == 4'd0, mask_reg == 4'd0 && m_tlast)
endmodule

// ===== rtl/pnce_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module pnce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== bench/pixel_neighbor_curvature_edges_test.sv =====
// Self-checking bench for pixel_neighbor_curvature_edges: drives raster pixels, predicts
// the right/down/diagonal edges and their curvature weights, checks every edge transfer.
// Depends on pnce_pkg and the RTL top level only.
module pixel_neighbor_curvature_edges_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH  = 1024;
    localparam int ROW_LIMIT   = 1024;
    localparam int SETTLE      = 80;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        bit                 has;
        bit                 ok;
        logic signed [15:0] p [3];
        logic signed [15:0] n [3];
        bit [19:0]          id;
    } pix_s;

    typedef struct {
        bit [19:0] from_id;
        bit [19:0] to_id;
        bit [15:0] weight;
        bit        last;
    } edge_s;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [10:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [95:0] s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    pixel_neighbor_curvature_edges uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // predictor state
    bit [10:0] columns_reg = 11'd640;
    bit [10:0] rows_reg    = 11'd480;
    pix_s      line_store [LINE_DEPTH];
    pix_s      left_pix, upleft_pix;
    int        col_cnt, row_cnt;
    bit [19:0] next_id;

    pix_s  pixel_queue [$];
    pix_s  offered;
    edge_s edge_queue [$];
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    recv_hold = 0;
    bit    hold_start = 0;
    int    hold_count = 0;

    function automatic bit [15:0] curvature(pix_s a, pix_s b);
        longint dot, side, c;
        longint unsigned m, r;
        dot = 0;
        side = 0;
        for (int k = 0; k < 3; k++) begin
            dot += longint'(a.n[k]) * longint'(b.n[k]);
            side += longint'(b.n[k]) * (longint'(b.p[k]) - longint'(a.p[k]));
        end
        c = (longint'(1) << 28) - dot;
        if (side > 0) begin
            m = (c < 0) ? longint'(-c) : c;
            r = (m * m + (64'd1 << 41)) >> 42;
        end else if (c <= 0) begin
            r = 0;
        end else begin
            r = (c + 8192) >> 14;
        end
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic void add_edge(pix_s a, pix_s b);
        edge_s e;
        if (!a.has || !b.has || !a.ok || !b.ok) return;
        e.from_id = a.id;
        e.to_id = b.id;
        e.weight = curvature(a, b);
        e.last = 0;
        edge_queue.insert(edge_queue.size(), e);
    endfunction

    function automatic void enqueue(pix_s q);
        pixel_queue.insert(pixel_queue.size(), q);
    endfunction

    function automatic void restart_frame();
        pix_s blank;
        col_cnt = 0;
        row_cnt = 0;
        next_id = 0;
        blank.has = 0;
        blank.ok = 0;
        blank.id = 0;
        for (int k = 0; k < 3; k++) begin
            blank.p[k] = 0;
            blank.n[k] = 0;
        end
        left_pix = blank;
        upleft_pix = blank;
    endfunction

    function automatic void predict_edges(pix_s cur_in);
        int   cols, rows, x, queued;
        pix_s cur, up, upright, ul;
        cols = (columns_reg < 1) ? 1 : (columns_reg > LINE_DEPTH ? LINE_DEPTH : columns_reg);
        rows = (rows_reg < 1) ? 1 : (rows_reg > ROW_LIMIT ? ROW_LIMIT : rows_reg);
        if (col_cnt >= cols) col_cnt = 0;
        if (row_cnt >= rows) row_cnt = 0;
        x = col_cnt;
        cur = cur_in;
        cur.id = next_id;
        up = left_pix;
        up.has = 0;
        up.ok = 0;
        up.id = 0;
        for (int k = 0; k < 3; k++) begin
            up.p[k] = 0;
            up.n[k] = 0;
        end
        upright = up;
        ul = upleft_pix;
        if (row_cnt > 0) begin
            up = line_store[x];
            if (x + 1 < cols) upright = line_store[x + 1];
        end
        if (x == 0 || row_cnt == 0) ul.has = 0;
        queued = edge_queue.size();
        if (cur.has) begin
            if (x > 0) add_edge(left_pix, cur);
            add_edge(ul, cur);
            add_edge(up, cur);
            add_edge(cur, upright);
            next_id = next_id + 1;
        end
        if (edge_queue.size() > queued) edge_queue[edge_queue.size() - 1].last = 1;
        upleft_pix = up;
        left_pix = cur;
        line_store[x] = cur;
        col_cnt = x + 1;
        if (col_cnt >= cols) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= rows) begin
                row_cnt = 0;
                next_id = 0;
            end
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_edges(offered);
            if (!s_tvalid || s_tready) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pixel_queue.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= {offered.n[2], offered.n[1], offered.n[0],
                                offered.p[2], offered.p[1], offered.p[0]};
                    s_tuser <= {offered.ok, offered.has};
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // long receiver hold, counted here
    always @(posedge aclk) begin
        if (hold_start && !recv_hold) begin
            recv_hold <= 1;
            hold_count <= 0;
        end else if (recv_hold) begin
            if (hold_count == HOLD_CYCLES - 1) recv_hold <= 0;
            hold_count <= hold_count + 1;
        end
    end

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // monitor
    always @(posedge aclk) begin
        edge_s e;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (edge_queue.size() == 0) begin
                    report("unexpected edge, from", m_tdata[19:0], -1);
                end else begin
                    e = edge_queue.pop_front();
                    if (m_tdata[19:0] != e.from_id) report("edge_from", m_tdata[19:0], e.from_id);
                    if (m_tdata[39:20] != e.to_id) report("edge_to", m_tdata[39:20], e.to_id);
                    if (m_tdata[55:40] != e.weight)
                        report("edge_weight", m_tdata[55:40], e.weight);
                    if (m_tlast != e.last) report("last_edge", m_tlast, e.last);
                end
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic pix_s make_pix(bit has, bit ok, int px, int py, int pz,
                                      int nx, int ny, int nz);
        pix_s q;
        q.has = has;
        q.ok = ok;
        q.id = 0;
        q.p[0] = px; q.p[1] = py; q.p[2] = pz;
        q.n[0] = nx; q.n[1] = ny; q.n[2] = nz;
        return q;
    endfunction

    pix_s prev_rand;

    function automatic pix_s rand_pix();
        pix_s q;
        q.has = $urandom_range(99) < 85;
        q.ok = $urandom_range(99) < 88;
        q.id = 0;
        for (int k = 0; k < 3; k++) begin
            q.p[k] = $urandom;
            case ($urandom_range(3))
                0:       q.n[k] = $urandom;
                1:       q.n[k] = prev_rand.n[k] + $urandom_range(400) - 200;
                default: q.n[k] = $urandom_range(32768) - 16384;
            endcase
        end
        // now and then reuse the last position so the side term is zero
        if ($urandom_range(9) == 0) q.p = prev_rand.p;
        else if ($urandom_range(3) == 0)
            for (int k = 0; k < 3; k++) q.p[k] = prev_rand.p[k] + $urandom_range(60) - 30;
        prev_rand = q;
        return q;
    endfunction

    task automatic drain();
        while (pixel_queue.size() > 0 || s_tvalid || edge_queue.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(bit idx, bit [10:0] value);
        drain();
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == pnce_pkg::CFG_COLUMNS) columns_reg = value;
        else rows_reg = value;
        restart_frame();
    endtask

    task automatic random_items(int count);
        repeat (count) enqueue(rand_pix());
    endtask

    initial begin
        prev_rand = make_pix(1, 1, 0, 0, 0, 16384, 0, 0);
        restart_frame();
        repeat (9) @(posedge aclk);
        aresetn <= 1;

        // defaults: a single long row, right edges only
        enqueue(make_pix(1, 1, 0, 0, 0, 16384, 0, 0));
        enqueue(make_pix(1, 1, 0, 0, 0, 16384, 0, 0));
        enqueue(make_pix(1, 1, 32767, 32767, 32767, -16384, 0, 0));
        enqueue(make_pix(1, 1, -32768, -32768, -32768, 16384, 0, 0));
        enqueue(make_pix(0, 1, 5, 5, 5, 0, 16384, 0));
        enqueue(make_pix(1, 0, 5, 5, 5, 0, 16384, 0));
        enqueue(make_pix(1, 1, 100, -100, 7, -32768, -32768, -32768));
        enqueue(make_pix(1, 1, -1, 1, 0, 32767, 32767, 32767));
        enqueue(make_pix(1, 1, 0, 0, 1000, 0, 0, 16384));

        write_reg(pnce_pkg::CFG_COLUMNS, 11'd3);
        write_reg(pnce_pkg::CFG_ROWS, 11'd2);
        // three-column frames: all four neighbor directions and frame wrap
        enqueue(make_pix(1, 1, 0, 0, 0, 0, 0, 16384));
        enqueue(make_pix(1, 1, 10, 0, 0, 0, 0, 16384));
        enqueue(make_pix(1, 1, 20, 0, 0, 0, 11585, 11585));
        enqueue(make_pix(1, 1, 0, 10, 5, 0, 0, -16384));
        enqueue(make_pix(1, 1, 10, 10, -5, 16384, 0, 0));
        enqueue(make_pix(1, 1, 20, 10, 0, 0, 0, 16384));
        enqueue(make_pix(0, 0, 0, 0, 0, 0, 0, 0));
        enqueue(make_pix(1, 1, 1, 1, 1, 0, 16384, 0));
        enqueue(make_pix(1, 0, 2, 2, 2, 0, 16384, 0));
        enqueue(make_pix(1, 1, 3, 3, 3, 0, -16384, 0));
        enqueue(make_pix(1, 1, 3, 3, 3, 0, -16384, 0));
        enqueue(make_pix(1, 1, -3, 9, 3, 0, 16384, 0));

        // no idling; long receiver hold so the block backs up
        write_reg(pnce_pkg::CFG_COLUMNS, 11'd5);
        write_reg(pnce_pkg::CFG_ROWS, 11'd4);
        random_items(40);
        hold_start <= 1;
        @(posedge aclk);
        hold_start <= 0;
        wait (recv_hold);
        wait (!recv_hold);
        drain();
        // sender paused above until all edges came; then carry on
        random_items(30);

        write_reg(pnce_pkg::CFG_COLUMNS, 11'd4);
        write_reg(pnce_pkg::CFG_ROWS, 11'd3);
        send_idle_pct = 60;
        random_items(60);

        write_reg(pnce_pkg::CFG_COLUMNS, 11'd7);
        write_reg(pnce_pkg::CFG_ROWS, 11'd5);
        send_idle_pct = 0;
        recv_stall_pct = 60;
        random_items(60);

        write_reg(pnce_pkg::CFG_COLUMNS, 11'd2);
        write_reg(pnce_pkg::CFG_ROWS, 11'd6);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        random_items(60);

        // register extremes, zero and oversize values clamp
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(pnce_pkg::CFG_COLUMNS, 11'd0);
        write_reg(pnce_pkg::CFG_ROWS, 11'd0);
        random_items(12);
        write_reg(pnce_pkg::CFG_COLUMNS, 11'd1);
        write_reg(pnce_pkg::CFG_ROWS, 11'd1024);
        random_items(12);
        write_reg(pnce_pkg::CFG_COLUMNS, 11'd2047);
        write_reg(pnce_pkg::CFG_ROWS, 11'd2047);
        random_items(12);
        write_reg(pnce_pkg::CFG_COLUMNS, 11'd1024);
        write_reg(pnce_pkg::CFG_ROWS, 11'd1);
        random_items(12);
        write_reg(pnce_pkg::CFG_COLUMNS, 11'd1);
        write_reg(pnce_pkg::CFG_ROWS, 11'd1);
        random_items(10);

        drain();
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #3ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
